// File: rtl/chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Types and constants shared by the chained hash identifier set.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int ID_W     = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int HANDLE_W = 8;

  // The remainder unit takes this many steps to form the bucket index.
  localparam int MOD_STEPS = 4;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_LOAD,
    S_FETCH,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_MISS,
    RES_ADDED,
    RES_PRESENT,
    RES_FULL,
    RES_HIT,
    RES_REMOVED
  } res_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic mod_step;
    logic load_head;
    logic advance;
    logic alloc;
    logic unlink;
    logic res_load;
    res_t res_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mod_done;
    logic cur_nil;
    logic match;
    logic pool_empty;
    logic out_full;
    act_t act;
  } sts_t;

endpackage

// File: rtl/chs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/chs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_mod
// Remainder unit: identifier modulo the bucket count by reciprocal multiply.
// ----------------------------------------------------------------------------
module chs_mod #(
  parameter int BUCKETS = 64,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    step,
  input  logic [chs_pkg::ID_W-1:0] ident,
  output logic [BW-1:0]           rem,
  output logic                    done
);

  import chs_pkg::*;

  localparam int HW     = ID_W / 2;
  localparam int MW     = ID_W + 1;
  localparam int PROD_W = HW + MW;
  localparam int ACC_W  = ID_W + MW;
  localparam int SHIFT  = ID_W + $clog2(BUCKETS);
  localparam logic [63:0] POW = 64'd1 << SHIFT;
  // The reciprocal is rounded up, which makes the quotient exact for every identifier.
  localparam logic [MW-1:0]   RECIP   = MW'((POW + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [ID_W-1:0] DIVISOR = ID_W'(BUCKETS);

  logic [ID_W-1:0]      idr;
  logic [ACC_W-1:0]     acc;
  logic [ID_W-1:0]      qb;
  logic [HW-1:0]        half;
  logic [PROD_W-1:0]    part;
  logic [ID_W-1:0]      quot;
  logic [MOD_CNT_W-1:0] cnt;

  assign half = cnt[0] ? idr[ID_W-1:HW] : idr[HW-1:0];
  assign part = PROD_W'(half) * PROD_W'(RECIP);
  assign quot = ID_W'(acc >> SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // The low half product comes first and the high half is added shifted up; the
  // quotient times the bucket count is then taken off the identifier.
  always_ff @(posedge clk) begin
    if (load) begin
      idr <= ident;
    end else if (step) begin
      case (cnt)
        MOD_CNT_W'(0): acc <= ACC_W'(part);
        MOD_CNT_W'(1): acc <= acc + {part, {HW{1'b0}}};
        MOD_CNT_W'(2): qb  <= quot * DIVISOR;
        default:       rem <= BW'(idr - qb);
      endcase
    end
  end

  assign done = (cnt == MOD_CNT_W'(MOD_STEPS - 1));

endmodule

// File: rtl/chs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ctrl
// Controller that sequences the clearing pass, remainder, chain walk and update.
// ----------------------------------------------------------------------------
module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd
);

  import chs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        // The bucket head read is in flight.
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_head = 1'b1;
        state_next    = S_FETCH;
      end
      S_FETCH: begin
        if (sts.cur_nil) begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
          if (sts.act == ACT_ADD) begin
            if (sts.pool_empty) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.alloc   = 1'b1;
              cmd.res_sel = RES_ADDED;
            end
          end else begin
            cmd.res_sel = RES_MISS;
          end
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
          case (sts.act)
            ACT_ADD:    cmd.res_sel = RES_PRESENT;
            ACT_LOOKUP: cmd.res_sel = RES_HIT;
            ACT_REMOVE: begin
              cmd.unlink  = 1'b1;
              cmd.res_sel = RES_REMOVED;
            end
            default:    cmd.res_sel = RES_MISS;
          endcase
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/chs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_dp
// Datapath: bucket heads, node pool, free stack, walk registers and result.
// ----------------------------------------------------------------------------
module chs_dp #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [chs_pkg::ACTION_W-1:0] action,
  input  logic [chs_pkg::ID_W-1:0]     window_id,
  input  chs_pkg::cmd_t                cmd,
  output chs_pkg::sts_t                sts,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [chs_pkg::STATUS_W-1:0] status,
  output logic                         found,
  output logic [chs_pkg::HANDLE_W-1:0] handle
);

  import chs_pkg::*;

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW   = $clog2(NODES);
  localparam int PW   = $clog2(NODES + 1);
  localparam int MAXN = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int CW   = $clog2(MAXN);

  // A pointer equal to the pool size marks the end of a chain.
  localparam logic [PW-1:0] NIL  = PW'(NODES);
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);

  logic [CW-1:0]       clr_cnt;
  logic [PW-1:0]       fcount;
  logic [ID_W-1:0]     id_q;
  act_t                act_q;
  logic [PW-1:0]       cur;
  logic [PW-1:0]       prev;
  logic [PW-1:0]       head_val;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [HANDLE_W-1:0] res_handle;

  logic [BW-1:0]   rem;
  logic            mod_done;
  logic [PW-1:0]   head_q;
  logic [ID_W-1:0] ident_q;
  logic [PW-1:0]   link_q;
  logic [IW-1:0]   stack_q;
  logic            prev_nil;
  logic            clr_bucket;
  logic            clr_stack;

  logic            head_we;
  logic [BW-1:0]   head_waddr;
  logic [PW-1:0]   head_wdata;
  logic            link_we;
  logic [IW-1:0]   link_waddr;
  logic [PW-1:0]   link_wdata;
  logic            stack_we;
  logic [IW-1:0]   stack_waddr;
  logic [IW-1:0]   stack_wdata;

  chs_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .load  (cmd.load_in),
    .step  (cmd.mod_step),
    .ident (window_id),
    .rem   (rem),
    .done  (mod_done)
  );

  assign prev_nil   = (prev == NIL);
  assign clr_bucket = cmd.clr_step && ({1'b0, clr_cnt} < (CW + 1)'(BUCKETS));
  assign clr_stack  = cmd.clr_step && ({1'b0, clr_cnt} < (CW + 1)'(NODES));

  // Write ports; the clearing pass, an add and a remove never overlap.
  always_comb begin
    head_we     = clr_bucket || cmd.alloc || (cmd.unlink && prev_nil);
    head_waddr  = cmd.clr_step ? clr_cnt[BW-1:0] : rem;
    head_wdata  = cmd.clr_step ? NIL : (cmd.alloc ? PW'(stack_q) : link_q);
    link_we     = cmd.alloc || (cmd.unlink && !prev_nil);
    link_waddr  = cmd.alloc ? stack_q : prev[IW-1:0];
    link_wdata  = cmd.alloc ? head_val : link_q;
    stack_we    = clr_stack || cmd.unlink;
    stack_waddr = cmd.clr_step ? clr_cnt[IW-1:0] : fcount[IW-1:0];
    stack_wdata = cmd.clr_step ? (LAST - clr_cnt[IW-1:0]) : cur[IW-1:0];
  end

  chs_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (rem),
    .rdata (head_q)
  );

  chs_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_ident_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (stack_q),
    .wdata (id_q),
    .raddr (cur[IW-1:0]),
    .rdata (ident_q)
  );

  chs_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (cur[IW-1:0]),
    .rdata (link_q)
  );

  // The top of the free stack is read continuously, so it is ready at a miss.
  chs_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (fcount[IW-1:0] - 1'b1),
    .rdata (stack_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      fcount    <= PW'(NODES);
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.alloc) begin
        fcount <= fcount - 1'b1;
      end else if (cmd.unlink) begin
        fcount <= fcount + 1'b1;
      end
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_q  <= window_id;
      act_q <= act_t'(action);
    end
    if (cmd.load_head) begin
      cur      <= head_q;
      prev     <= NIL;
      head_val <= head_q;
    end else if (cmd.advance) begin
      prev <= cur;
      cur  <= link_q;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ADDED: begin
          res_status <= ST_OK;
          res_found  <= 1'b1;
          res_handle <= HANDLE_W'(stack_q);
        end
        RES_PRESENT: begin
          res_status <= ST_PRESENT;
          res_found  <= 1'b1;
          res_handle <= HANDLE_W'(cur);
        end
        RES_HIT: begin
          res_status <= ST_OK;
          res_found  <= 1'b1;
          res_handle <= HANDLE_W'(cur);
        end
        RES_FULL: begin
          res_status <= ST_FULL;
          res_found  <= 1'b0;
          res_handle <= '0;
        end
        RES_REMOVED: begin
          res_status <= ST_OK;
          res_found  <= 1'b0;
          res_handle <= '0;
        end
        default: begin
          res_status <= ST_ABSENT;
          res_found  <= 1'b0;
          res_handle <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      status <= res_status;
      found  <= res_found;
      handle <= res_handle;
    end
  end

  always_comb begin
    sts.clear_done = (clr_cnt == CW'(MAXN - 1));
    sts.mod_done   = mod_done;
    sts.cur_nil    = (cur >= NIL);
    sts.match      = (ident_q == id_q);
    sts.pool_empty = (fcount == '0);
    sts.out_full   = out_valid && out_stall;
    sts.act        = act_q;
  end

endmodule

// File: rtl/chained_hash_id_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_id_set
// Set of 32-bit identifiers in a separately chained hash table.
// ----------------------------------------------------------------------------
// One item is handled at a time. After reset the block runs a clearing pass
// that empties every chain and fills the free stack, and it takes no item
// until that pass ends. An item then passes through the remainder unit, which
// forms the bucket index by multiplying with a fixed reciprocal, then a read
// of the bucket head, then a read of the node memories and a compare for each
// chain node visited; the result register is loaded at a match or at the end
// of the chain. A new item is accepted once the previous result sits in the
// output register.
// ----------------------------------------------------------------------------
module chained_hash_id_set #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [chs_pkg::ACTION_W-1:0] action,
  input  logic [chs_pkg::ID_W-1:0]     window_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [chs_pkg::STATUS_W-1:0] status,
  output logic                         found,
  output logic [chs_pkg::HANDLE_W-1:0] handle
);

  import chs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  chs_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .window_id (window_id),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .found     (found),
    .handle    (handle)
  );

endmodule

// File: rtl/chs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the chained hash identifier set.
// ----------------------------------------------------------------------------
module chs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [chs_pkg::STATUS_W-1:0] status,
  input logic                         found,
  input logic [chs_pkg::HANDLE_W-1:0] handle
);

  import chs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(found) && $stable(handle))
    else $error("stalled result item changed");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == ST_OK) || (status == ST_PRESENT))
    else $error("found set with a failing status");

  a_present_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PRESENT) |-> found)
    else $error("already present reported without found");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (handle == '0))
    else $error("handle nonzero without found");

endmodule

bind chained_hash_id_set chs_checker u_chs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .found     (found),
  .handle    (handle)
);

// File: test/chained_hash_id_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_id_set_tb
// Self-checking bench for the chained hash identifier set.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the bucket chains, node pool and
// free stack, predicts the outcome of every accepted item and compares each
// delivered result in order. Stimulus opens with hand-picked chain cases, then
// fills the pool to exhaustion and drains it, then runs random mixes aimed at
// a few crowded buckets under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module chained_hash_id_set_tb;
  import chs_pkg::*;

  localparam int BUCKETS = 64;
  localparam int NODES   = 256;
  localparam int NIL     = NODES;
  localparam int MAX_SHOWN = 100;
  // Longest chain walk plus head read and result load.
  localparam int SETTLE_CYCLES = 12 + 2 * NODES + 64;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] op;
    logic [ID_W-1:0]     key;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [HANDLE_W-1:0] handle;
  } outcome_t;

  class id_set_scoreboard;
    int              chain_head [BUCKETS];
    logic [ID_W-1:0] slot_id [NODES];
    int              slot_next [NODES];
    int              spare [NODES];
    int              spare_cnt;
    outcome_t        pending [$];
    logic [ID_W-1:0] held [$];
    logic [ID_W-1:0] gone [$];
    int              errors;
    int              accepted;
    int              status_seen [4];

    function void clear_table();
      for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
      for (int i = 0; i < NODES; i++) begin
        slot_id[i]   = '0;
        slot_next[i] = NIL;
        spare[i]     = NODES - 1 - i;
      end
      spare_cnt = NODES;
      errors    = 0;
      accepted  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_input(logic [ACTION_W-1:0] op, logic [ID_W-1:0] key);
      int       b;
      int       cur;
      int       prev;
      int       node;
      outcome_t e;
      b    = int'(key % BUCKETS);
      cur  = chain_head[b];
      prev = NIL;
      node = NIL;
      for (int steps = 0; steps < NODES && cur < NODES; steps++) begin
        if (slot_id[cur] == key) begin
          node = cur;
          break;
        end
        prev = cur;
        cur  = slot_next[cur];
      end
      e.op = op;
      e.key = key;
      e.status = ST_ABSENT;
      e.found = 1'b0;
      e.handle = '0;
      case (op)
        ACT_ADD: begin
          if (node != NIL) begin
            e.status = ST_PRESENT;
            e.found  = 1'b1;
            e.handle = node[HANDLE_W-1:0];
          end else if (spare_cnt == 0) begin
            e.status = ST_FULL;
          end else begin
            spare_cnt--;
            node = spare[spare_cnt];
            slot_id[node]   = key;
            slot_next[node] = chain_head[b];
            chain_head[b]   = node;
            e.status = ST_OK;
            e.found  = 1'b1;
            e.handle = node[HANDLE_W-1:0];
            held.push_back(key);
          end
        end
        ACT_REMOVE: begin
          if (node != NIL) begin
            if (prev == NIL) chain_head[b] = slot_next[node];
            else slot_next[prev] = slot_next[node];
            slot_next[node] = NIL;
            spare[spare_cnt] = node;
            spare_cnt++;
            e.status = ST_OK;
            for (int i = 0; i < held.size(); i++) begin
              if (held[i] == key) begin
                held.delete(i);
                break;
              end
            end
            gone.push_back(key);
            if (gone.size() > 32) void'(gone.pop_front());
          end
        end
        ACT_LOOKUP: begin
          if (node != NIL) begin
            e.status = ST_OK;
            e.found  = 1'b1;
            e.handle = node[HANDLE_W-1:0];
          end
        end
        default: ;
      endcase
      accepted++;
      status_seen[e.status]++;
      pending.push_back(e);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $realtime, what);
      if (errors == MAX_SHOWN) $display("Further mismatches are counted but not shown.");
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic found, logic [HANDLE_W-1:0] handle);
      outcome_t e;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing outstanding: status %0d found %0d handle %0d",
                         status, found, handle));
      end else begin
        e = pending.pop_front();
        if (status !== e.status)
          report($sformatf("action %0d id %h: status %0d, predicted %0d",
                           e.op, e.key, status, e.status));
        if (found !== e.found)
          report($sformatf("action %0d id %h: found %0d, predicted %0d",
                           e.op, e.key, found, e.found));
        if (handle !== e.handle)
          report($sformatf("action %0d id %h: handle %0d, predicted %0d",
                           e.op, e.key, handle, e.handle));
      end
    endtask

    task check_leftover();
      if (pending.size() != 0)
        report($sformatf("%0d results never delivered", pending.size()));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     window_id;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [HANDLE_W-1:0] handle;

  id_set_scoreboard sb;
  int gap_pct;
  int stall_pct;

  chained_hash_id_set #(
    .BUCKETS(BUCKETS),
    .NODES  (NODES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .window_id(window_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .found    (found),
    .handle   (handle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Run did not finish in the allowed time.");
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall decided at the falling edge, results taken at the rising edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(status, found, handle);
    end
  end

  task automatic send_item(input logic [ACTION_W-1:0] op, input logic [ID_W-1:0] key);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    action    = op;
    window_id = key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, key);
  endtask

  // Hold off the sender until every predicted result has been delivered.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(ACT_LOOKUP, 32'h0000_0000);
    send_item(ACT_REMOVE, 32'hFFFF_FFFF);
    send_item(ACT_ADD,    32'h0000_0000);
    send_item(ACT_ADD,    32'h0000_0000);
    send_item(ACT_ADD,    32'hFFFF_FFFF);
    // Three identifiers share bucket zero: the chain becomes 80, 40, 0.
    send_item(ACT_ADD,    32'h0000_0040);
    send_item(ACT_ADD,    32'h0000_0080);
    send_item(ACT_LOOKUP, 32'h0000_0000);
    send_item(ACT_LOOKUP, 32'h0000_0040);
    send_item(ACT_REMOVE, 32'h0000_0040);
    send_item(ACT_LOOKUP, 32'h0000_0040);
    send_item(ACT_REMOVE, 32'h0000_0000);
    send_item(ACT_REMOVE, 32'h0000_0080);
    send_item(ACT_LOOKUP, 32'h0000_00C0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF);
    send_item(ACT_ADD,    32'hAAAA_AAAA);
    send_item(ACT_ADD,    32'h5555_5555);
    send_item(ACT_LOOKUP, 32'hAAAA_AAAA);
    send_item(ACT_REMOVE, 32'h5555_5555);
    send_item(ACT_REMOVE, 32'hFFFF_FFFF);
    send_item(ACT_REMOVE, 32'hAAAA_AAAA);
    send_item(ACT_UNUSED, 32'h0000_0000);
  endtask

  // Exhaust the node pool, probe it while full, then free every node.
  task automatic fill_and_drain();
    logic [ID_W-1:0] order [$];
    logic [ID_W-1:0] tmp;
    int              j;
    while (sb.spare_cnt > 0) send_item(ACT_ADD, $urandom());
    send_item(ACT_ADD, $urandom());
    send_item(ACT_ADD, sb.held[0]);
    repeat (8) send_item(ACT_LOOKUP, sb.held[$urandom_range(sb.held.size() - 1)]);
    order = sb.held;
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_item(ACT_REMOVE, order[i]);
  endtask

  // Most identifiers land in a few crowded buckets so that chains grow long.
  task automatic run_random(input int count);
    logic [ACTION_W-1:0] op;
    logic [ID_W-1:0]     key;
    logic [ID_W-1:0]     rnd;
    int                  r;
    int                  hot;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) op = ACT_ADD;
      else if (r < 68) op = ACT_REMOVE;
      else if (r < 98) op = ACT_LOOKUP;
      else op = ACT_UNUSED;
      r   = $urandom_range(99);
      rnd = $urandom();
      case ($urandom_range(3))
        0: hot = 0;
        1: hot = 1;
        2: hot = BUCKETS - 1;
        default: hot = $urandom_range(BUCKETS - 1);
      endcase
      if (r < 45 && sb.held.size() != 0) key = sb.held[$urandom_range(sb.held.size() - 1)];
      else if (r < 55 && sb.gone.size() != 0) key = sb.gone[$urandom_range(sb.gone.size() - 1)];
      else if (r < 85) key = rnd - (rnd % BUCKETS) + hot;
      else key = rnd;
      send_item(op, key);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_table();
    gap_pct   = 0;
    stall_pct = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACT_ADD;
    window_id = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    wait_drained();
    fill_and_drain();
    wait_drained();

    gap_pct = 81;
    stall_pct = 0;
    run_random(360);
    wait_drained();

    gap_pct = 0;
    stall_pct = 81;
    run_random(360);
    wait_drained();

    gap_pct = 33;
    stall_pct = 33;
    run_random(360);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_leftover();
    $display("Covered %0d items: %0d ok, %0d already present, %0d pool full, %0d not found.",
             sb.accepted, sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT],
             sb.status_seen[ST_FULL], sb.status_seen[ST_ABSENT]);
    $display("Pool filled and drained; random mixes ran with gaps, stalls and both.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: chained_hash_id_set.f
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chs_mod.sv
rtl/chs_ctrl.sv
rtl/chs_dp.sv
rtl/chained_hash_id_set.sv
rtl/chs_checker.sv
test/chained_hash_id_set_tb.sv
